// ===== rtl/core/smx_pkg.sv =====
// ----------------------------------------------------------------------------
// smx_pkg: shared types and constants for the stack machine executor
// Opcodes, status codes, sequencer states and ALU control struct.
// ----------------------------------------------------------------------------
package smx_pkg;

	localparam int unsigned StackDepthDef = 64;
	localparam int unsigned WordW = 64;

	typedef enum logic [2:0] {
		OP_PUSH    = 3'd0,
		OP_ADD     = 3'd1,
		OP_SUB     = 3'd2,
		OP_MUL     = 3'd3,
		OP_DIV     = 3'd4,
		OP_POP     = 3'd5,
		OP_DONE    = 3'd6,
		OP_UNKNOWN = 3'd7
	} op_t;

	typedef enum logic [2:0] {
		ST_SUCCESS   = 3'd0,
		ST_DONE      = 3'd1,
		ST_DIV_ZERO  = 3'd2,
		ST_UNKNOWN   = 3'd3,
		ST_UNDERFLOW = 3'd4,
		ST_OVERFLOW  = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_RD_TOP,
		S_RD_BELOW,
		S_EXEC,
		S_WAIT_ALU,
		S_WRITE,
		S_OUT
	} state_t;

	// start request from the sequencer to the shared arithmetic unit
	typedef struct packed {
		logic start;
		op_t  op;
	} alu_req_t;

endpackage

// ===== rtl/core/smx_if.sv =====
// ----------------------------------------------------------------------------
// smx_in_if / smx_out_if: valid/ready channels of the stack machine executor
// Instruction channel and result channel, each with source and sink views.
// ----------------------------------------------------------------------------
interface smx_in_if;
	logic       valid;
	logic       ready;
	logic [2:0] kind;
	logic [7:0] immediate;

	modport source (output valid, kind, immediate, input ready);
	modport sink (input valid, kind, immediate, output ready);
endinterface

interface smx_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [63:0] accumulator;

	modport source (output valid, status, accumulator, input ready);
	modport sink (input valid, status, accumulator, output ready);
endinterface

// ===== rtl/core/smx_alu.sv =====
// ----------------------------------------------------------------------------
// smx_alu: shared iterative 64-bit arithmetic unit
// Add/sub registered from the start request; shift-add multiply and restoring
// divide, one bit per cycle.
// ----------------------------------------------------------------------------
module smx_alu (
	input  logic                 clk,
	input  logic                 arst_n,
	input  smx_pkg::alu_req_t    req,
	input  logic [63:0]          below,
	input  logic [63:0]          top,
	output logic                 done,
	output logic [63:0]          result
);
	import smx_pkg::*;

	logic        busy_q;
	logic [5:0]  cnt_q;
	op_t         op_q;
	logic [63:0] acc_q;    // product accumulator / remainder
	logic [63:0] a_q;      // multiplicand / dividend-quotient shifter
	logic [63:0] b_q;      // multiplier / divisor
	logic        done_q;
	logic [64:0] trial;

	// restoring divide trial subtract
	assign trial = {acc_q, a_q[63]} - {1'b0, b_q};

	// control: busy, bit counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				if (req.op == OP_MUL || req.op == OP_DIV) begin
					busy_q <= 1'b1;
					cnt_q  <= '0;
				end else begin
					done_q <= 1'b1;
				end
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd63) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (req.start) begin
			op_q <= req.op;
			unique case (req.op)
				OP_ADD: acc_q <= below + top;
				OP_SUB: acc_q <= below - top;
				default: acc_q <= '0;
			endcase
			a_q <= (req.op == OP_MUL) ? top : below;
			b_q <= (req.op == OP_MUL) ? below : top;
		end else if (busy_q) begin
			if (op_q == OP_MUL) begin
				if (a_q[0]) acc_q <= acc_q + b_q;
				a_q <= a_q >> 1;
				b_q <= b_q << 1;
			end else begin
				if (!trial[64]) begin
					acc_q <= trial[63:0];
					a_q   <= {a_q[62:0], 1'b1};
				end else begin
					acc_q <= {acc_q[62:0], a_q[63]};
					a_q   <= {a_q[62:0], 1'b0};
				end
			end
		end
	end

	assign done   = done_q;
	assign result = (op_q == OP_DIV) ? a_q : acc_q;

`ifndef NO_ASSERTIONS
	a_no_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !req.start) else $error("alu started while busy");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q) else $error("alu done longer than one cycle");
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q) else $error("alu done while busy");
`endif

endmodule

// ===== rtl/core/stack_machine_executor.sv =====
// ----------------------------------------------------------------------------
// stack_machine_executor: 64-bit operand stack machine, one instruction/item
// Sequencer around a stack memory and a shared iterative arithmetic unit.
// ----------------------------------------------------------------------------
//  channel   dir  fields                        transfer
//  in_ch     in   kind[2:0] immediate[7:0]      valid & ready
//  out_ch    out  status[2:0] accumulator[63:0] valid & ready
//
//  States per item, accept through result transfer: push, done, unknown and
//  underflow/overflow: RD_TOP, OUT; pop: RD_TOP, WRITE (extra result load), OUT.
//  Add/sub: RD_TOP, RD_BELOW (two stack reads through the single read port), EXEC,
//  WAIT_ALU (unit), WRITE, OUT; mul/div wait on the 64 one-bit steps; div by zero:
//  EXEC then OUT. One item at a time: in_ch.ready is high only while the sequencer
//  idles; a stalled result holds the block. Stack memory needs no clear on reset.
// ----------------------------------------------------------------------------
module stack_machine_executor #(
	parameter int unsigned STACK_DEPTH = smx_pkg::StackDepthDef
) (
	input  logic       clk,
	input  logic       arst_n,
	smx_in_if.sink     in_ch,
	smx_out_if.source  out_ch
);
	import smx_pkg::*;

	localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int unsigned PW = $clog2(STACK_DEPTH + 1);
	localparam logic [PW-1:0] DepthP = PW'(STACK_DEPTH);

	state_t        state_q, state_d;
	logic [PW-1:0] sp_q;
	op_t           op_q;
	logic [7:0]    imm_q;
	logic [63:0]   top_q, rd_data_q, acc_q;
	status_t       status_q;
	logic [63:0]   mem [STACK_DEPTH];
	logic          mem_we;
	logic [AW-1:0] wr_addr, rd_addr;
	logic [63:0]   wr_data;
	logic          alu_done;
	logic [63:0]   alu_result;
	alu_req_t      alu_req;
	logic          in_xfer, out_xfer;
	logic          err;

	assign in_xfer  = in_ch.valid && in_ch.ready;
	assign out_xfer = out_ch.valid && out_ch.ready;

	// stack memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) mem[wr_addr] <= wr_data;
		rd_data_q <= mem[rd_addr];
	end

	// decode the early error cases from op and pointer
	always_comb begin
		err = 1'b0;
		unique case (op_q)
			OP_PUSH: err = (sp_q >= DepthP);
			OP_ADD, OP_SUB, OP_MUL, OP_DIV: err = (sp_q < PW'(2));
			OP_POP: err = (sp_q == '0);
			default: err = 1'b1;
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:     if (in_xfer) state_d = S_RD_TOP;
			S_RD_TOP: begin
				if (err || op_q == OP_PUSH) state_d = S_OUT;
				else state_d = (op_q == OP_POP) ? S_WRITE : S_RD_BELOW;
			end
			S_RD_BELOW: state_d = S_EXEC;
			S_EXEC: begin
				if (op_q == OP_DIV && top_q == '0) state_d = S_OUT;
				else state_d = S_WAIT_ALU;
			end
			S_WAIT_ALU: if (alu_done) state_d = S_WRITE;
			S_WRITE:    state_d = S_OUT;
			S_OUT:      if (out_xfer) state_d = S_IDLE;
			default:    state_d = S_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		mem_we        = 1'b0;
		wr_addr       = sp_q[AW-1:0];
		wr_data       = {56'd0, imm_q};
		rd_addr       = AW'(sp_q - PW'(1));
		alu_req.start = 1'b0;
		alu_req.op    = op_q;
		unique case (state_q)
			S_RD_TOP: begin
				mem_we = (op_q == OP_PUSH) && !err;
			end
			S_RD_BELOW: rd_addr = AW'(sp_q - PW'(2));
			S_EXEC: alu_req.start = !(op_q == OP_DIV && top_q == '0);
			S_WAIT_ALU: begin
				wr_addr = AW'(sp_q - PW'(2));
				wr_data = alu_result;
				mem_we  = alu_done;
			end
			default: ;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			sp_q     <= '0;
			acc_q    <= '0;
			status_q <= ST_SUCCESS;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				S_RD_TOP: begin
					if (err) begin
						sp_q <= '0;
						unique case (op_q)
							OP_PUSH:    status_q <= ST_OVERFLOW;
							OP_DONE:    status_q <= ST_DONE;
							OP_UNKNOWN: status_q <= ST_UNKNOWN;
							default:    status_q <= ST_UNDERFLOW;
						endcase
					end else begin
						status_q <= ST_SUCCESS;
						if (op_q == OP_PUSH) sp_q <= sp_q + PW'(1);
					end
				end
				S_EXEC: begin
					if (op_q == OP_DIV && top_q == '0) begin
						status_q <= ST_DIV_ZERO;
						sp_q     <= '0;
					end
				end
				S_WRITE: begin
					sp_q <= sp_q - PW'(1);
					if (op_q == OP_POP) acc_q <= rd_data_q;
				end
				default: ;
			endcase
		end
	end

	// instruction and top operand capture; the lower operand is on the read port in exec
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			op_q  <= op_t'(in_ch.kind);
			imm_q <= in_ch.immediate;
		end
		if (state_q == S_RD_BELOW) top_q <= rd_data_q;
	end

	smx_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (alu_req),
		.below  (rd_data_q),
		.top    (top_q),
		.done   (alu_done),
		.result (alu_result)
	);

	assign in_ch.ready        = (state_q == S_IDLE);
	assign out_ch.valid       = (state_q == S_OUT);
	assign out_ch.status      = status_q;
	assign out_ch.accumulator = acc_q;

`ifndef NO_ASSERTIONS
	a_sp_bound: assert property (@(posedge clk) disable iff (!arst_n)
		sp_q <= DepthP) else $error("stack pointer beyond depth");
	a_err_empties: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && status_q != ST_SUCCESS |-> sp_q == '0)
		else $error("error status with nonempty stack");
	a_alu_only_exec: assert property (@(posedge clk) disable iff (!arst_n)
		alu_req.start |-> state_q == S_EXEC) else $error("alu started outside exec");
	a_accept_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> state_q == S_RD_TOP) else $error("accept did not start sequence");
`endif

endmodule
